// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CGDO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define CGDO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cgdo_pkg.sv =====
`default_nettype none
package cgdo_pkg;

    // Map geometry; the 5-bit coordinate fields bound the span.
    localparam int GRID_SPAN        = 16;
    localparam int SIDE             = GRID_SPAN + 1;
    localparam int CELLS            = SIDE * SIDE;
    localparam int COORD_W          = 5;
    localparam int RA_W             = $clog2(SIDE);
    localparam int COUNT_W          = $clog2(CELLS + 1);
    localparam int MAX_DISTANCE_DEF = 4;
    localparam int LEVEL_W          = 3;
    localparam int QUEUE_DEPTH      = 4;

    // Stream beat widths.
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_READ     = 2'd1,
        KIND_READ_OOR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               land;
    } t_job;

endpackage
`default_nettype wire

// ===== design/cgdo_ram.sv =====
`default_nettype none
module cgdo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

// ===== design/cgdo_front.sv =====
`default_nettype none
module cgdo_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_req_type,
    input  wire logic [cgdo_pkg::COORD_W-1:0] i_row,
    input  wire logic [cgdo_pkg::COORD_W-1:0] i_col,
    input  wire logic                  i_land,
    output logic                       o_job_valid,
    output cgdo_pkg::t_job             o_job,
    input  wire logic                  i_job_pop
);

    localparam int QP_W  = $clog2(cgdo_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cgdo_pkg::QUEUE_DEPTH + 1);

    cgdo_pkg::t_job   r_q [cgdo_pkg::QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    logic           accept, in_range, push, pop;
    cgdo_pkg::t_job job;

    assign o_ready = (r_cnt != CNT_W'(cgdo_pkg::QUEUE_DEPTH));
    assign accept  = i_valid && o_ready;

    always_comb begin
        in_range = (i_row <= cgdo_pkg::COORD_W'(cgdo_pkg::GRID_SPAN)) &&
                   (i_col <= cgdo_pkg::COORD_W'(cgdo_pkg::GRID_SPAN));
        job.row  = i_row;
        job.col  = i_col;
        job.land = i_land;
        if (!i_req_type) begin
            job.kind = cgdo_pkg::KIND_WRITE;
        end else if (in_range) begin
            job.kind = cgdo_pkg::KIND_READ;
        end else begin
            job.kind = cgdo_pkg::KIND_READ_OOR;
        end
    end

    // off-map writes change nothing: taken and dropped here
    assign push        = accept && (i_req_type || in_range);
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rd_ptr];
    assign pop         = i_job_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QP_W'(cgdo_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QP_W'(cgdo_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= job;
        end
    end

endmodule
`default_nettype wire

// ===== design/cgdo_back.sv =====
`default_nettype none
module cgdo_back #(
    parameter int MAX_DISTANCE = cgdo_pkg::MAX_DISTANCE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_job_valid,
    input  cgdo_pkg::t_job                    i_job,
    output logic                              o_job_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [cgdo_pkg::LEVEL_W-1:0]      o_level
);

    localparam int SIDE    = cgdo_pkg::SIDE;
    localparam int RA_W    = cgdo_pkg::RA_W;
    localparam int COORD_W = cgdo_pkg::COORD_W;
    localparam int LEVEL_W = cgdo_pkg::LEVEL_W;
    localparam int COUNT_W = cgdo_pkg::COUNT_W;
    localparam int K_W     = $clog2(MAX_DISTANCE + 1);
    localparam int EXT_W   = ((COORD_W > K_W) ? COORD_W : K_W) + 1;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_WR_RD    = 6'b000010,
        ST_WR_WB    = 6'b000100,
        ST_RD_SCAN  = 6'b001000,
        ST_RD_DRAIN = 6'b010000,
        ST_RESULT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    cgdo_pkg::t_job       r_job;
    logic [K_W-1:0]       r_k, n_k;
    logic [K_W-1:0]       r_eval_k;
    logic                 r_eval_vld, n_eval_vld;
    logic                 r_map_a, r_map_b, r_rv_a, r_rv_b;
    logic [K_W-1:0]       r_best, n_best;
    logic [COUNT_W-1:0]   r_ocean_cnt, n_ocean_cnt;
    logic [SIDE-1:0]      r_row_vld, n_row_vld;
    logic                 r_out_valid, n_out_valid;
    logic [LEVEL_W-1:0]   r_out_level;

    logic [RA_W-1:0]  raddr_a, raddr_b;
    logic [SIDE-1:0]  rdata_a, rdata_b;
    logic             we;
    logic [SIDE-1:0]  wdata, old_row;
    logic             map_a, map_b;
    logic [EXT_W-1:0] row_p, row_m;
    logic             take_job, out_free;
    logic [LEVEL_W-1:0] level;

    // ring evaluation
    logic [SIDE-1:0]  ocean_ab;
    logic             found;
    logic [K_W-1:0]   cand;
    logic [EXT_W-1:0] colp, colm;

    cgdo_ram #(
        .WIDTH (SIDE),
        .DEPTH (SIDE)
    ) u_map (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (r_job.row[RA_W-1:0]),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign out_free  = !r_out_valid || i_ready;
    assign take_job  = (r_state == ST_IDLE) && i_job_valid;
    assign o_job_pop = take_job;
    assign o_valid   = r_out_valid;
    assign o_level   = r_out_level;

    // rows r-k and r+k for the scan step
    always_comb begin
        row_p = EXT_W'(r_job.row) + EXT_W'(r_k);
        row_m = EXT_W'(r_job.row) - EXT_W'(r_k);
        map_b = (row_p <= EXT_W'(cgdo_pkg::GRID_SPAN));
        map_a = (EXT_W'(r_k) <= EXT_W'(r_job.row));
        if (r_state == ST_RD_SCAN) begin
            raddr_a = map_a ? row_m[RA_W-1:0] : '0;
            raddr_b = map_b ? row_p[RA_W-1:0] : '0;
        end else begin
            raddr_a = r_job.row[RA_W-1:0];
            raddr_b = '0;
        end
    end

    // unwritten rows are all ocean; rows off the map hold none
    always_comb begin
        ocean_ab = '0;
        if (r_map_a) ocean_ab = ocean_ab | (r_rv_a ? ~rdata_a : '1);
        if (r_map_b) ocean_ab = ocean_ab | (r_rv_b ? ~rdata_b : '1);
        found = 1'b0;
        cand  = K_W'(MAX_DISTANCE);
        for (int j = 0; j < MAX_DISTANCE; j++) begin
            colp = EXT_W'(r_job.col) + EXT_W'(j);
            colm = EXT_W'(r_job.col) - EXT_W'(j);
            if (!found && (int'(r_eval_k) + j < MAX_DISTANCE)) begin
                if ((colp <= EXT_W'(cgdo_pkg::GRID_SPAN) && ocean_ab[colp[RA_W-1:0]]) ||
                    (EXT_W'(j) <= EXT_W'(r_job.col) && ocean_ab[colm[RA_W-1:0]])) begin
                    found = 1'b1;
                    cand  = K_W'(int'(r_eval_k) + j);
                end
            end
        end
    end

    // write path: merge the land bit into the row read the cycle before
    always_comb begin
        old_row = r_rv_a ? rdata_a : '0;
        wdata   = old_row;
        wdata[r_job.col[RA_W-1:0]] = r_job.land;
        we      = (r_state == ST_WR_WB);
    end

    always_comb begin
        if (r_job.kind == cgdo_pkg::KIND_READ_OOR) begin
            level = '0;
        end else if (r_ocean_cnt == '0) begin
            level = LEVEL_W'(MAX_DISTANCE + 1);
        end else if (r_best < K_W'(MAX_DISTANCE)) begin
            level = LEVEL_W'(K_W'(MAX_DISTANCE) - r_best);
        end else begin
            level = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_eval_vld  = 1'b0;
        n_best      = r_best;
        n_ocean_cnt = r_ocean_cnt;
        n_row_vld   = r_row_vld;
        n_out_valid = r_out_valid && !i_ready;

        if (r_eval_vld && found && (cand < r_best)) begin
            n_best = cand;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.kind)
                        cgdo_pkg::KIND_WRITE: n_state = ST_WR_RD;
                        cgdo_pkg::KIND_READ:  n_state = ST_RD_SCAN;
                        default:              n_state = ST_RESULT;
                    endcase
                    n_k    = '0;
                    n_best = K_W'(MAX_DISTANCE);
                end
            end
            ST_WR_RD: begin
                n_state = ST_WR_WB;
            end
            ST_WR_WB: begin
                n_row_vld[r_job.row[RA_W-1:0]] = 1'b1;
                if (old_row[r_job.col[RA_W-1:0]] != r_job.land) begin
                    n_ocean_cnt = r_job.land ? r_ocean_cnt - 1'b1 : r_ocean_cnt + 1'b1;
                end
                n_state = ST_IDLE;
            end
            ST_RD_SCAN: begin
                n_eval_vld = 1'b1;
                n_k        = r_k + 1'b1;
                if (r_k == K_W'(MAX_DISTANCE - 1)) begin
                    n_state = ST_RD_DRAIN;
                end
            end
            ST_RD_DRAIN: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_eval_vld  <= 1'b0;
            r_best      <= '0;
            r_ocean_cnt <= COUNT_W'(cgdo_pkg::CELLS);
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_eval_vld  <= n_eval_vld;
            r_best      <= n_best;
            r_ocean_cnt <= n_ocean_cnt;
            r_row_vld   <= n_row_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_job) begin
            r_job <= i_job;
        end
        r_eval_k <= r_k;
        r_map_a  <= map_a;
        r_map_b  <= map_b;
        r_rv_a   <= r_row_vld[raddr_a];
        r_rv_b   <= r_row_vld[raddr_b];
        if (r_state == ST_RESULT && out_free) begin
            r_out_level <= level;
        end
    end

endmodule
`default_nettype wire

// ===== design/clamped_grid_distance_to_ocean.sv =====
// Clamped distance-to-ocean on a 17 x 17 land/ocean map.
//
// Input stream (s side): one beat per request. tuser carries the request
// type (0 write one cell's land bit, 1 read one cell's humidity level);
// tdata carries row, column and land bit. Writes give no beat out; every
// read gives exactly one beat on the m side, in request order.
// Humidity is MAX_DISTANCE minus the clamped Manhattan distance to the
// nearest ocean cell, MAX_DISTANCE + 1 if the map has no ocean, and 0 for
// a read outside the map.
// A small request queue decouples intake from the map engine, so beats are
// taken while the engine works or a result waits on the m side.
// Engine steps: a read is dispatched, then scans one row pair r-k / r+k
// per cycle through the dual-read map RAM, then passes a drain state and
// a result state; a write does a row read, then a merge and write back,
// after its dispatch. Off-map writes are dropped at intake. The engine
// takes no new job from the queue until it is back in idle.
// Reset (synchronous, active low) empties the queue and marks every row
// unwritten, so the whole map reads as ocean at once; no clearing pass.
// A stalled m side holds the result beat; the engine waits with the next
// read result until it is taken, and the queue fills, then drops tready.
`default_nettype none
module clamped_grid_distance_to_ocean #(
    parameter int MAX_DISTANCE = cgdo_pkg::MAX_DISTANCE_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request beats
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // [4:0] cell_row, [9:5] cell_col, [10] land_bit, [15:11] zero
    input  wire logic [cgdo_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [0] req_type
    input  wire logic                               i_s_tuser,
    // result beats
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [2:0] humidity_level, [7:3] zero
    output logic [cgdo_pkg::OUT_DATA_W-1:0]         o_m_tdata
);

    localparam int COORD_W = cgdo_pkg::COORD_W;

    logic                          job_valid, job_pop;
    cgdo_pkg::t_job                job;
    logic [cgdo_pkg::LEVEL_W-1:0]  level;

    // intake and classify
    cgdo_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_req_type  (i_s_tuser),
        .i_row       (i_s_tdata[COORD_W-1:0]),
        .i_col       (i_s_tdata[2*COORD_W-1:COORD_W]),
        .i_land      (i_s_tdata[2*COORD_W]),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    // map store, ring scan and result register
    cgdo_back #(
        .MAX_DISTANCE (MAX_DISTANCE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_level     (level)
    );

    assign o_m_tdata = {{(cgdo_pkg::OUT_DATA_W - cgdo_pkg::LEVEL_W){1'b0}}, level};

endmodule
`default_nettype wire

// ===== design/cgdo_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module cgdo_checker #(
    parameter int MAX_DISTANCE = cgdo_pkg::MAX_DISTANCE_DEF
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_tvalid,
    input wire logic                           o_s_tready,
    input wire logic [cgdo_pkg::IN_DATA_W-1:0] i_s_tdata,
    input wire logic                           i_s_tuser,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [cgdo_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    // result beat held until taken
    `CGDO_ASSERT(a_m_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "m beat dropped or changed while stalled")

    // level within range, padding zero
    `CGDO_ASSERT(a_level_range, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata[cgdo_pkg::OUT_DATA_W-1:cgdo_pkg::LEVEL_W] == '0) && ((MAX_DISTANCE >= 7) || (int'(o_m_tdata[cgdo_pkg::LEVEL_W-1:0]) <= MAX_DISTANCE + 1)), "humidity level out of range")

    // no result beat right after reset
    `CGDO_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_m_tvalid, "m beat valid after reset")

    // queue empty after reset, so the s side is ready
    `CGDO_ASSERT_ALWAYS(a_rst_ready, i_clk, !i_rst_n |=> o_s_tready, "s side not ready after reset")

endmodule

bind clamped_grid_distance_to_ocean cgdo_checker #(
    .MAX_DISTANCE (MAX_DISTANCE)
) u_cgdo_checker (.*);
`default_nettype wire

// ===== tb/sv/clamped_grid_distance_to_ocean_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module clamped_grid_distance_to_ocean_test;

    localparam int GRID_SPAN  = cgdo_pkg::GRID_SPAN;
    localparam int SIDE       = cgdo_pkg::SIDE;
    localparam int CELLS      = cgdo_pkg::CELLS;
    localparam int LEVEL_W    = cgdo_pkg::LEVEL_W;
    localparam int IN_DATA_W  = cgdo_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = cgdo_pkg::OUT_DATA_W;

    // request type codes carried on tuser
    localparam bit REQ_WRITE = 1'b0;
    localparam bit REQ_READ  = 1'b1;

    localparam int MAX_DIST       = cgdo_pkg::MAX_DISTANCE_DEF;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MIX_ITEMS      = 210;

    typedef struct {
        bit       rd;
        bit [4:0] row;
        bit [4:0] col;
        bit       land;
    } t_cell_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  s_user = 1'b0;
    logic                  m_ready = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic [OUT_DATA_W-1:0] m_data;

    t_cell_req             req_backlog[$];  // beats waiting for the driver
    bit [LEVEL_W-1:0]      humidity_due[$]; // predicted read results, oldest first

    // predictor state: 1 = land
    bit                    land_cells[CELLS];
    int                    ocean_cells;

    t_cell_req             beat;
    bit                    s_taken = 1'b0;
    bit [LEVEL_W-1:0]      due_level;
    int                    errors = 0;
    int                    s_idle_pct = 0;
    int                    r_idle_pct = 0;
    int                    rx_hold_left = 0;
    int                    hold_asked = 0;
    int                    hold_done = 0;

    clamped_grid_distance_to_ocean u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),  // [4:0] row, [9:5] col, [10] land, [15:11] zero
        .i_s_tuser  (s_user),  // [0] req type
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data)   // [2:0] humidity, [7:3] zero
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic bit ocean_at(int r, int c);
        if (r < 0 || c < 0 || r > GRID_SPAN || c > GRID_SPAN)
            return 1'b0;
        return !land_cells[r * SIDE + c];
    endfunction

    // MAX_DIST minus clamped Manhattan distance to nearest ocean cell; 0 off the map, MAX_DIST + 1 with no ocean
    function automatic bit [LEVEL_W-1:0] humidity_at(int r, int c);
        int rest;
        if (r > GRID_SPAN || c > GRID_SPAN)
            return '0;
        if (ocean_cells == 0)
            return LEVEL_W'(MAX_DIST + 1);
        for (int d = 0; d < MAX_DIST; d++) begin
            for (int dr = -d; dr <= d; dr++) begin
                rest = d - (dr < 0 ? -dr : dr);
                if (ocean_at(r + dr, c + rest) || ocean_at(r + dr, c - rest))
                    return LEVEL_W'(MAX_DIST - d);
            end
        end
        return '0;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > GRID_SPAN)
            return GRID_SPAN;
        return v;
    endfunction

    // ---------------- stimulus helpers ----------------

    task automatic push_req(bit rd, int row, int col, bit land);
        t_cell_req req;
        req.rd   = rd;
        req.row  = row[4:0];
        req.col  = col[4:0];
        req.land = land;
        req_backlog.push_back(req);
    endtask

    // sender pause: nothing queued, nothing on the bus, no result outstanding;
    // looked at just after the falling edge so the driver's update is seen
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
            #1;
        end while (req_backlog.size() != 0 || s_valid || humidity_due.size() != 0);
    endtask

    // whole map to land, so later reads see sparse ocean only
    task automatic fill_land();
        for (int r = 0; r <= GRID_SPAN; r++)
            for (int c = 0; c <= GRID_SPAN; c++)
                push_req(REQ_WRITE, r, c, 1'b1);
    endtask

    // Mostly islands of ocean: drop a few ocean cells near a center, read
    // around it out to beyond MAX_DIST, then usually turn them back to land.
    // The rest is raw noise over the full field ranges.
    task automatic run_coast_mix(int target);
        int done;
        int r0;
        int c0;
        int k;
        int n;
        int orow[3];
        int ocol[3];
        done = 0;
        while (done < target) begin
            if ($urandom_range(99) < 18) begin
                push_req($urandom_range(1), $urandom_range(31), $urandom_range(31),
                         $urandom_range(1));
                done++;
            end else begin
                k  = $urandom_range(3);
                r0 = $urandom_range(GRID_SPAN);
                c0 = $urandom_range(GRID_SPAN);
                for (int i = 0; i < k; i++) begin
                    orow[i] = clamp_coord(r0 + $urandom_range(6) - 3);
                    ocol[i] = clamp_coord(c0 + $urandom_range(6) - 3);
                    push_req(REQ_WRITE, orow[i], ocol[i], 1'b0);
                    done++;
                end
                n = $urandom_range(8, 3);
                for (int j = 0; j < n; j++) begin
                    push_req(REQ_READ, clamp_coord(r0 + $urandom_range(10) - 5),
                             clamp_coord(c0 + $urandom_range(10) - 5), $urandom_range(1));
                    done++;
                end
                if ($urandom_range(99) < 85) begin
                    for (int i = 0; i < k; i++) begin
                        push_req(REQ_WRITE, orow[i], ocol[i], 1'b1);
                        done++;
                    end
                end
            end
        end
    endtask

    // ---------------- driver: request side ----------------

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_valid || s_taken)) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
                beat = req_backlog.pop_front();
                s_valid <= 1'b1;
                s_data  <= {5'b0, beat.land, beat.col, beat.row};
                s_user  <= beat.rd;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- result side ready ----------------

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (hold_asked != hold_done) begin
            rx_hold_left <= RX_HOLD_CYCLES;
            hold_done    <= hold_done + 1;
        end
    end

    always @(negedge i_clk) begin
        m_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= r_idle_pct);
    end

    // ---------------- monitor, checker and state update ----------------

    always @(posedge i_clk) begin
        s_taken <= s_valid && s_ready;
        if (i_rst_n) begin
            // result beat first: never belongs to a request taken this edge
            if (m_valid && m_ready) begin
                if (humidity_due.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: result beat %0h with no read outstanding",
                                 $realtime, m_data);
                    errors++;
                end else begin
                    due_level = humidity_due.pop_front();
                    if (m_data !== {{(OUT_DATA_W - LEVEL_W){1'b0}}, due_level}) begin
                        if (errors < 10)
                            $display("%0t: humidity mismatch: expected %0d, got %0h",
                                     $realtime, due_level, m_data);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_user == REQ_READ) begin
                    humidity_due.push_back(humidity_at(s_data[4:0], s_data[9:5]));
                end else if (s_data[4:0] <= GRID_SPAN && s_data[9:5] <= GRID_SPAN) begin
                    // off-map writes leave map and count alone
                    if (land_cells[s_data[4:0] * SIDE + s_data[9:5]] != s_data[10]) begin
                        land_cells[s_data[4:0] * SIDE + s_data[9:5]] = s_data[10];
                        ocean_cells = s_data[10] ? ocean_cells - 1 : ocean_cells + 1;
                    end
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        foreach (land_cells[i])
            land_cells[i] = 1'b0;
        ocean_cells = CELLS;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: all-ocean map after reset, off-map reads and writes,
        // then land spreading from the corner until it is beyond reach
        push_req(REQ_READ, 0, 0, 1'b0);
        push_req(REQ_READ, GRID_SPAN, GRID_SPAN, 1'b0);
        push_req(REQ_READ, 31, 31, 1'b1);
        push_req(REQ_READ, 0, GRID_SPAN + 1, 1'b0);
        push_req(REQ_READ, GRID_SPAN + 1, 0, 1'b0);
        push_req(REQ_WRITE, 20, 3, 1'b1);
        push_req(REQ_WRITE, 3, 31, 1'b1);
        push_req(REQ_WRITE, 0, 0, 1'b0);
        push_req(REQ_WRITE, 0, 0, 1'b1);
        push_req(REQ_READ, 0, 0, 1'b1);
        push_req(REQ_WRITE, 0, 1, 1'b1);
        push_req(REQ_WRITE, 1, 0, 1'b1);
        push_req(REQ_READ, 0, 0, 1'b0);
        push_req(REQ_WRITE, 0, 2, 1'b1);
        push_req(REQ_WRITE, 1, 1, 1'b1);
        push_req(REQ_WRITE, 2, 0, 1'b1);
        push_req(REQ_READ, 0, 0, 1'b0);
        for (int i = 0; i <= 3; i++)
            push_req(REQ_WRITE, i, 3 - i, 1'b1);
        push_req(REQ_READ, 0, 0, 1'b1);
        push_req(REQ_READ, GRID_SPAN, 0, 1'b1);
        wait_idle();

        // three idling profiles: sender light / receiver heavy, swapped, none
        for (int ph = 0; ph < 3; ph++) begin
            s_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 47 : 0;
            r_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 8 : 0;
            fill_land();
            // no ocean left anywhere
            for (int i = 0; i < 3; i++)
                push_req(REQ_READ, $urandom_range(GRID_SPAN), $urandom_range(GRID_SPAN),
                         $urandom_range(1));
            wait_idle();
            // receiver stalls while a burst of reads piles up behind it
            hold_asked++;
            push_req(REQ_WRITE, $urandom_range(GRID_SPAN), $urandom_range(GRID_SPAN), 1'b0);
            for (int i = 0; i < 24; i++)
                push_req(REQ_READ, $urandom_range(GRID_SPAN), $urandom_range(GRID_SPAN),
                         $urandom_range(1));
            run_coast_mix(MIX_ITEMS);
            wait_idle();
        end

        // catch stray beats after the last expected one
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
